// File: sv/lbf_pkg.sv
// Shared types, codes and helpers for the learning bridge forwarder.
package lbf_pkg;

	localparam logic [1:0] PORT_NONE  = 2'd0;
	localparam logic [1:0] PORT_LOCAL = 2'd1;
	localparam logic [1:0] PORT_ETH   = 2'd2;
	localparam logic [1:0] PORT_RADIO = 2'd3;

	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
	localparam logic [15:0] MCAST_PREFIX = 16'h3333;
	localparam logic [15:0] EUI_FILL     = 16'hFFFE;

	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	typedef struct packed {
		logic [1:0]  in_port;
		logic [63:0] src_address;
		logic [63:0] dst_address;
		logic [7:0]  ip_protocol;
	} in_req_t;

	typedef struct packed {
		logic [1:0] out_port;
		logic       to_local;
		logic       to_radio;
		logic       to_ethernet;
		logic       dropped;
		logic       source_learned;
	} out_rsp_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [1:0]  port;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRC,
		ST_VICTIM,
		ST_LEARN,
		ST_DST,
		ST_DONE
	} state_t;

	// Expand a 48-bit MAC into the 64-bit form with FF:FE in the middle.
	function automatic logic [63:0] eth_to_long(input logic [63:0] e);
		eth_to_long = {e[47:24], EUI_FILL, e[23:0]};
	endfunction

endpackage

// File: sv/lbf_table.sv
// Address table memory: one write port, one registered read port.
module lbf_table
	import lbf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lbf_victim.sv
// Eviction picker: LFSR step, then the slot as the new value modulo the table depth.
module lbf_victim
	import lbf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic [IW-1:0] slot
);

	// ceil(2^32 / DEPTH); the top product bits give the exact quotient of a 16-bit value
	localparam longint RECIP_L = (64'd4294967296 + DEPTH - 1) / DEPTH;
	localparam logic [31:0]       RECIP   = 32'(RECIP_L);
	localparam logic [LFSR_W-1:0] DEPTH_W = LFSR_W'(DEPTH);

	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_next;
	logic [LFSR_W+31:0] prod;
	logic [LFSR_W-1:0]  quot_s1;
	logic [LFSR_W-1:0]  back;
	logic [LFSR_W-1:0]  diff;
	logic [IW-1:0]      rem_q;
	logic               busy_q;
	logic               phase_q;
	logic               fb;

	assign fb        = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign lfsr_next = {fb, lfsr_q[LFSR_W-1:1]};
	assign prod      = {32'b0, lfsr_q} * {{LFSR_W{1'b0}}, RECIP};
	assign back      = quot_s1 * DEPTH_W;
	assign diff      = lfsr_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= LFSR_SEED;
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (start) begin
			lfsr_q  <= lfsr_next;
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q) begin
			phase_q <= 1'b1;
			if (phase_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient by reciprocal multiply, then the remainder by subtracting it back
	always_ff @(posedge clk) begin
		if (busy_q && !phase_q) begin
			quot_s1 <= prod[LFSR_W+31:32];
		end
		if (busy_q && phase_q) begin
			rem_q <= diff[IW-1:0];
		end
	end

	assign busy = busy_q;
	assign slot = rem_q;

endmodule

// File: sv/learning_bridge_forwarder.sv
// Top level of the learning bridge forwarder: control sequencer and result register.
// Scans: with a full table the eviction adds a slot pick and the second scan is one entry
// shorter than with room left. Both table scans share the single read port of the table
// memory, one entry per cycle.
// Throughput: one request at a time; the next is taken the cycle after the result is
// registered, and a result held by the receiver stalls the next request.
// Reset: the table starts empty, the LFSR loads 0xACE1; table contents are not cleared.
module learning_bridge_forwarder
	import lbf_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_rsp_t out_data,
	input  logic     cfg_wr_en,
	input  logic [63:0] cfg_wr_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	// request context
	logic [1:0]  port_q;
	logic [63:0] src_q;
	logic [63:0] dst_q;
	logic [7:0]  proto_q;
	logic        learned_q;
	logic        hit_q;
	logic [1:0]  hit_port_q;

	// table bookkeeping and scan pointer
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rv_s1;
	logic          table_full;
	logic          issue;
	logic          match;
	logic          scan_end;

	// table ports
	logic    mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t  mem_wdata;
	entry_t  mem_rdata;

	// victim picker
	logic          vic_start;
	logic          vic_busy;
	logic [IW-1:0] vic_slot;

	// result register
	logic     out_valid_q;
	out_rsp_t out_q;
	out_rsp_t rsp;
	logic     out_free;

	logic [63:0] src_norm;
	logic [63:0] dst_norm;

	// Normalize ethernet addresses at the door, multicast destinations to zero; other ports pass them through.
	always_comb begin
		src_norm = in_data.src_address;
		dst_norm = in_data.dst_address;
		if (in_data.in_port == PORT_ETH) begin
			src_norm = eth_to_long(in_data.src_address);
			if (in_data.dst_address[47:32] == MCAST_PREFIX) begin
				dst_norm = '0;
			end else begin
				dst_norm = eth_to_long(in_data.dst_address);
			end
		end
	end

	assign table_full = (count_q >= CW'(TABLE_DEPTH));
	assign issue      = (idx_q < count_q);
	// compare the entry whose read was issued last cycle
	assign match      = rv_s1 &&
		(mem_rdata.addr == ((state_q == ST_SRC) ? src_q : dst_q));
	assign scan_end   = !issue && !rv_s1;
	assign out_free   = !out_valid_q || out_ready;

	// Config write loads entry zero; otherwise the learn step writes the new source.
	assign mem_we    = cfg_wr_en || (state_q == ST_LEARN);
	assign mem_wdata = cfg_wr_en ? entry_t'{addr: cfg_wr_data, port: PORT_LOCAL}
	                             : entry_t'{addr: src_q, port: port_q};
	assign mem_waddr = cfg_wr_en ? '0 : (table_full ? vic_slot : count_q[IW-1:0]);

	lbf_table #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	lbf_victim #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_victim (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vic_start),
		.busy   (vic_busy),
		.slot   (vic_slot)
	);

	// Build the delivery decision from the lookup and the arrival port.
	always_comb begin
		rsp = '0;
		rsp.source_learned = learned_q;
		if (dst_q == '0 || !hit_q) begin
			rsp.out_port = PORT_NONE;
			case (port_q)
				PORT_ETH: begin
					rsp.to_radio = 1'b1;
					rsp.to_local = 1'b1;
				end
				PORT_RADIO: begin
					rsp.to_ethernet = 1'b1;
					rsp.to_local    = 1'b1;
				end
				PORT_LOCAL: begin
					rsp.to_radio    = 1'b1;
					rsp.to_ethernet = 1'b1;
				end
				default: begin
					rsp.dropped = 1'b1;
				end
			endcase
		end else begin
			rsp.out_port = hit_port_q;
			case (hit_port_q)
				PORT_LOCAL: rsp.to_local    = 1'b1;
				PORT_RADIO: rsp.to_radio    = 1'b1;
				PORT_ETH:   rsp.to_ethernet = 1'b1;
				default:    rsp.dropped     = 1'b1;
			endcase
		end
		// refused protocol: keep the lookup, clear delivery
		if (proto_q != PROTO_UDP && proto_q != PROTO_ICMPV6) begin
			rsp.to_local    = 1'b0;
			rsp.to_radio    = 1'b0;
			rsp.to_ethernet = 1'b0;
			rsp.dropped     = 1'b1;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		vic_start = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SRC;
				end
			end
			ST_SRC: begin
				if (match) begin
					state_d = ST_DST;
				end else if (scan_end) begin
					if (table_full) begin
						vic_start = 1'b1;
						state_d   = ST_VICTIM;
					end else begin
						state_d = ST_LEARN;
					end
				end
			end
			ST_VICTIM: begin
				if (!vic_busy) begin
					state_d = ST_LEARN;
				end
			end
			ST_LEARN: begin
				state_d = ST_DST;
			end
			ST_DST: begin
				if (match || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table fill count: config restarts it at one, learning advances it until full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= CW'(1);
		end else if (state_q == ST_LEARN && !table_full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Scan pointer and read-valid flag; restart at each scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rv_s1 <= 1'b0;
		end else if ((state_q == ST_SRC || state_q == ST_DST) && state_d == state_q) begin
			rv_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end else begin
			idx_q <= '0;
			rv_s1 <= 1'b0;
		end
	end

	// Capture the request and the lookup results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				learned_q <= 1'b0;
			end else if (state_q == ST_LEARN) begin
				learned_q <= 1'b1;
			end
			if (state_q == ST_DST && state_d == ST_DONE) begin
				hit_q <= match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			port_q  <= in_data.in_port;
			src_q   <= src_norm;
			dst_q   <= dst_norm;
			proto_q <= in_data.ip_protocol;
		end
		if (state_q == ST_DST && match) begin
			hit_port_q <= mem_rdata.port;
		end
	end

	// Result register: hold until taken, load from the done step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("table count above depth");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cfg_wr_en || state_q == ST_LEARN))
		else $error("table write outside learn or config");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done step");

	a_rv_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_SRC || state_q == ST_DST))
		else $error("read valid outside a scan");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRC || state_q == ST_DST) |-> idx_q <= count_q)
		else $error("scan pointer past table count");
`endif

endmodule
